// ===== sv/ptts_pkg.sv =====
package ptts_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_W    = 4;

    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_DEL  = 3'd1;
    localparam logic [2:0] CMD_QRY  = 3'd2;
    localparam logic [2:0] CMD_TICK = 3'd3;
    localparam logic [2:0] CMD_DSP  = 3'd4;

    localparam logic [1:0] ST_RUNNABLE = 2'd0;
    localparam logic [1:0] ST_RUNNING  = 2'd1;
    localparam logic [1:0] ST_STOPPED  = 2'd2;
    localparam logic [1:0] ST_ERROR    = 2'd3;

    localparam logic [1:0] K_ADD  = 2'd0;
    localparam logic [1:0] K_DEL  = 2'd1;
    localparam logic [1:0] K_STAT = 2'd2;
    localparam logic [1:0] K_FIRE = 2'd3;

    localparam logic [15:0] TICK_DIV_RST = 16'd392;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  task_key;
        logic [15:0] period;
    } t_item;

    typedef struct packed {
        logic [1:0] resp_kind;
        logic [7:0] out_task;
        logic [3:0] slot_index;
        logic [1:0] task_status;
        logic       ok;
        logic       last;
    } t_result;

    typedef struct packed {
        logic             accept;
        logic             scan;
        logic             flush;
        logic             last_slot;
        logic [IDX_W-1:0] idx;
        logic [2:0]       op;
    } t_dp_ctl;

    typedef struct packed {
        logic hit;
        logic wrap;
    } t_dp_sts;

endpackage

// ===== sv/ptts_ctrl.sv =====
module ptts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [2:0]        i_cmd,
    input  ptts_pkg::t_dp_sts i_sts,
    output logic              busy,
    output ptts_pkg::t_dp_ctl o_ctl
);
    import ptts_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [2:0]       r_op, n_op;
    logic             accept;
    logic             last_slot;

    assign accept    = start && (r_state == S_IDLE);
    assign last_slot = (r_idx == LAST_IDX);
    assign busy      = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_op    = r_op;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    n_op = i_cmd;
                    case (i_cmd) inside
                        CMD_ADD, CMD_DEL, CMD_QRY, CMD_DSP: n_state = S_SCAN;
                        CMD_TICK: begin
                            if (i_sts.wrap) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_sts.hit && (r_op == CMD_ADD || r_op == CMD_DEL || r_op == CMD_QRY)) begin
                    n_state = S_IDLE;
                end else if (last_slot) begin
                    n_state = (r_op == CMD_DSP) ? S_FLUSH : S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FLUSH: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_op    <= CMD_ADD;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_op    <= n_op;
        end
    end

    always_comb begin
        o_ctl.accept    = accept;
        o_ctl.scan      = (r_state == S_SCAN);
        o_ctl.flush     = (r_state == S_FLUSH);
        o_ctl.last_slot = last_slot;
        o_ctl.idx       = r_idx;
        o_ctl.op        = r_op;
    end

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !accept) |=> (r_state == S_IDLE))
        else $error("controller left idle without a command");

    a_flush_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> (r_state == S_IDLE))
        else $error("flush did not return to idle");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && last_slot) |=> (r_state != S_SCAN))
        else $error("scan ran past the last slot");

endmodule

// ===== sv/ptts_dp.sv =====
module ptts_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptts_pkg::t_dp_ctl i_ctl,
    input  ptts_pkg::t_item   i_item,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    output ptts_pkg::t_dp_sts o_sts,
    output logic              o_result_valid,
    output ptts_pkg::t_result o_result
);
    import ptts_pkg::*;

    logic [7:0]  r_slot_key [NUM_SLOTS];
    logic [15:0] r_slot_per [NUM_SLOTS];
    logic [15:0] r_slot_cd  [NUM_SLOTS];
    logic [1:0]  r_slot_st  [NUM_SLOTS];

    logic [15:0] r_tick_div;
    logic [15:0] r_pre;
    logic [7:0]  r_key_q;
    logic [15:0] r_per_q;

    logic        r_out_vld, n_out_vld;
    t_result     r_out, n_out;
    logic        r_pend_vld, n_pend_vld;
    t_result     r_pend, n_pend;

    logic [7:0]  cur_key;
    logic [15:0] cur_per;
    logic [15:0] cur_cd;
    logic [1:0]  cur_st;
    logic        hit;
    logic        wrap;
    logic [3:0]  slot_no;

    assign cur_key = r_slot_key[i_ctl.idx];
    assign cur_per = r_slot_per[i_ctl.idx];
    assign cur_cd  = r_slot_cd[i_ctl.idx];
    assign cur_st  = r_slot_st[i_ctl.idx];
    assign slot_no = SLOT_W'(i_ctl.idx);
    assign wrap    = ({1'b0, r_pre} + 17'd1) >= {1'b0, r_tick_div};

    always_comb begin
        case (i_ctl.op) inside
            CMD_ADD:          hit = (cur_st == ST_STOPPED);
            CMD_DEL, CMD_QRY: hit = (cur_key == r_key_q);
            CMD_DSP:          hit = (cur_st == ST_RUNNABLE) && (cur_cd == '0);
            default:          hit = 1'b0;
        endcase
    end

    assign o_sts.hit  = hit;
    assign o_sts.wrap = wrap;

    always_comb begin
        n_out_vld  = 1'b0;
        n_out      = r_out;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        if (i_ctl.scan) begin
            case (i_ctl.op) inside
                CMD_ADD, CMD_DEL, CMD_QRY: begin
                    if (hit || i_ctl.last_slot) begin
                        n_out_vld        = 1'b1;
                        n_out.out_task   = r_key_q;
                        n_out.last       = 1'b1;
                        n_out.slot_index = hit ? slot_no : '0;
                        n_out.ok         = hit && (i_ctl.op != CMD_QRY);
                        if (i_ctl.op == CMD_ADD) begin
                            n_out.resp_kind   = K_ADD;
                            n_out.task_status = hit ? ST_RUNNABLE : ST_ERROR;
                        end else if (i_ctl.op == CMD_DEL) begin
                            n_out.resp_kind   = K_DEL;
                            n_out.task_status = hit ? ST_STOPPED : ST_ERROR;
                        end else begin
                            n_out.resp_kind   = K_STAT;
                            n_out.task_status = hit ? cur_st : ST_ERROR;
                        end
                    end
                end
                CMD_DSP: begin
                    if (hit) begin
                        if (r_pend_vld) begin
                            n_out_vld  = 1'b1;
                            n_out      = r_pend;
                            n_out.last = 1'b0;
                        end
                        n_pend_vld         = 1'b1;
                        n_pend.resp_kind   = K_FIRE;
                        n_pend.out_task    = cur_key;
                        n_pend.slot_index  = slot_no;
                        n_pend.task_status = ST_RUNNABLE;
                        n_pend.ok          = 1'b1;
                        n_pend.last        = 1'b1;
                    end
                end
                default: n_out_vld = 1'b0;
            endcase
        end
        if (i_ctl.flush && r_pend_vld) begin
            n_out_vld  = 1'b1;
            n_out      = r_pend;
            n_out.last = 1'b1;
            n_pend_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot_key[i] <= '0;
                r_slot_per[i] <= '0;
                r_slot_cd[i]  <= '0;
                r_slot_st[i]  <= ST_STOPPED;
            end
        end else if (i_ctl.scan) begin
            case (i_ctl.op) inside
                CMD_ADD: begin
                    if (hit) begin
                        r_slot_key[i_ctl.idx] <= r_key_q;
                        r_slot_per[i_ctl.idx] <= r_per_q;
                        r_slot_cd[i_ctl.idx]  <= r_per_q;
                        r_slot_st[i_ctl.idx]  <= ST_RUNNABLE;
                    end
                end
                CMD_DEL: begin
                    if (hit) begin
                        r_slot_st[i_ctl.idx] <= ST_STOPPED;
                    end
                end
                CMD_TICK: begin
                    if (cur_st == ST_RUNNABLE && cur_cd != '0) begin
                        r_slot_cd[i_ctl.idx] <= cur_cd - 16'd1;
                    end
                end
                CMD_DSP: begin
                    if (hit) begin
                        r_slot_cd[i_ctl.idx] <= cur_per;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_div <= TICK_DIV_RST;
            r_pre      <= '0;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tick_div <= i_cfg_data;
            end
            if (i_ctl.accept && i_item.cmd == CMD_TICK) begin
                r_pre <= wrap ? 16'd0 : r_pre + 16'd1;
            end
            r_out_vld  <= n_out_vld;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_key_q <= i_item.task_key;
            r_per_q <= i_item.period;
        end
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.resp_kind != K_FIRE) |-> r_out.last)
        else $error("command reply without last flag");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.flush |=> !r_pend_vld)
        else $error("pending fire survived the flush");

    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.resp_kind == K_FIRE) |-> (r_out.ok && r_out.task_status == ST_RUNNABLE))
        else $error("fire beat with wrong status");

endmodule

// ===== sv/periodic_task_table_scheduler.sv =====
// Periodic task table scheduler with sixteen slots.
// A command beat (add, delete, query, tick or dispatch) is taken at a clock
// edge where start is high and busy is low. Each slot is examined in turn, one
// slot per clock cycle, so the single table port sets the pace.
// Add, delete and query give one result beat, from the slot that decides the
// answer, or once the last slot has been examined when no slot does.
// A tick only steps the prescaler unless the prescaler wraps; then each slot is
// scanned and each runnable countdown that is not yet zero is stepped down.
// Dispatch scans every slot, then passes a flush state, and gives one fire beat
// per qualifying slot in slot order, the final one flagged by last.
// A command that gives no result gives no beat at all. The next command can be
// taken in the cycle in which the final result beat is presented.
// Results appear on o_result for exactly one cycle, marked by o_result_valid;
// the receiver cannot stall them.
// The tick divider is written through its own valid/ready channel, which is
// ready whenever the block is idle and no command is being offered.
// Synchronous reset stops every slot, clears keys, periods, countdowns and the
// prescaler, and restores the tick divider to 392; no clearing pass follows.
module periodic_task_table_scheduler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ptts_pkg::t_item   i_item,
    output logic              o_result_valid,
    output ptts_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [15:0]       i_cfg_data
);
    import ptts_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;

    assign o_cfg_ready = !busy && !start;

    ptts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_item.cmd),
        .i_sts   (sts),
        .busy    (busy),
        .o_ctl   (ctl)
    );

    ptts_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_sts          (sts),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

// ===== dv/periodic_task_table_scheduler_tb.sv =====
module periodic_task_table_scheduler_tb;

    import ptts_pkg::*;

    localparam logic [2:0] CMD_BAD_LO = 3'd5;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;
    localparam int         N_PHASES   = 8;
    localparam int         PHASE_CMDS = 60;
    localparam int         SETTLE     = 24;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_item       it;
        int          reps;
        bit          typed;
        t_result     want;
        logic [15:0] div;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_result_valid;
    t_result     o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    logic [7:0]  tbl_key    [NUM_SLOTS];
    logic [15:0] tbl_period [NUM_SLOTS];
    logic [15:0] tbl_count  [NUM_SLOTS];
    logic [1:0]  tbl_state  [NUM_SLOTS];
    logic [15:0] presc;
    logic [15:0] tick_div;

    t_result     step_replies [$];
    t_result     awaited [$];
    t_result     want_beat;
    t_stim_row   plan [$];
    int          errors = 0;

    periodic_task_table_scheduler i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic int find_slot(logic [7:0] key);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tbl_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Works out the replies of one command and updates the table copy.
    function automatic void sched_step(t_item it);
        int  idx;
        bit  done;
        step_replies.delete();
        case (it.cmd)
            CMD_ADD: begin
                done = 1'b0;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!done && tbl_state[i] == ST_STOPPED) begin
                        tbl_key[i]    = it.task_key;
                        tbl_period[i] = it.period;
                        tbl_count[i]  = it.period;
                        tbl_state[i]  = ST_RUNNABLE;
                        step_replies.push_back(t_result'{K_ADD, it.task_key, 4'(i),
                                                         ST_RUNNABLE, 1'b1, 1'b1});
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    step_replies.push_back(t_result'{K_ADD, it.task_key, 4'd0,
                                                     ST_ERROR, 1'b0, 1'b1});
                end
            end
            CMD_DEL: begin
                idx = find_slot(it.task_key);
                if (idx >= 0) begin
                    tbl_state[idx] = ST_STOPPED;
                    step_replies.push_back(t_result'{K_DEL, it.task_key, 4'(idx),
                                                     ST_STOPPED, 1'b1, 1'b1});
                end else begin
                    step_replies.push_back(t_result'{K_DEL, it.task_key, 4'd0,
                                                     ST_ERROR, 1'b0, 1'b1});
                end
            end
            CMD_QRY: begin
                idx = find_slot(it.task_key);
                if (idx >= 0) begin
                    step_replies.push_back(t_result'{K_STAT, it.task_key, 4'(idx),
                                                     tbl_state[idx], 1'b0, 1'b1});
                end else begin
                    step_replies.push_back(t_result'{K_STAT, it.task_key, 4'd0,
                                                     ST_ERROR, 1'b0, 1'b1});
                end
            end
            CMD_TICK: begin
                if (int'(presc) + 1 >= int'(tick_div)) begin
                    presc = '0;
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (tbl_state[i] == ST_RUNNABLE && tbl_count[i] != 0) begin
                            tbl_count[i] = tbl_count[i] - 16'd1;
                        end
                    end
                end else begin
                    presc = presc + 16'd1;
                end
            end
            CMD_DSP: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (tbl_state[i] == ST_RUNNABLE && tbl_count[i] == 0) begin
                        step_replies.push_back(t_result'{K_FIRE, tbl_key[i], 4'(i),
                                                         ST_RUNNABLE, 1'b1, 1'b0});
                        tbl_count[i] = tbl_period[i];
                    end
                end
                if (step_replies.size() > 0) begin
                    step_replies[step_replies.size() - 1].last = 1'b1;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_stim_row cmd_row(t_item it, int reps = 1, bit typed = 1'b0,
                                          t_result want = '0);
        t_stim_row r;
        r.kind  = ROW_ITEM;
        r.it    = it;
        r.reps  = reps;
        r.typed = typed;
        r.want  = want;
        r.div   = '0;
        return r;
    endfunction

    function automatic t_stim_row div_row(logic [15:0] v);
        t_stim_row r;
        r.kind  = ROW_CFG;
        r.it    = '0;
        r.reps  = 0;
        r.typed = 1'b0;
        r.want  = '0;
        r.div   = v;
        return r;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    pick;
        pick        = $urandom_range(0, 99);
        it.task_key = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7))
                                                 : 8'($urandom_range(0, 255));
        it.period   = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 6))
                                                 : 16'($urandom_range(0, 65535));
        if (pick < 20) begin
            it.cmd = CMD_ADD;
        end else if (pick < 32) begin
            it.cmd = CMD_DEL;
        end else if (pick < 45) begin
            it.cmd = CMD_QRY;
        end else if (pick < 78) begin
            it.cmd = CMD_TICK;
        end else if (pick < 95) begin
            it.cmd = CMD_DSP;
        end else begin
            it.cmd = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
        end
        return it;
    endfunction

    // Start stays high after acceptance; the caller lowers it only for a pause or a drain.
    task automatic issue(t_item it, bit typed, t_result want);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sched_step(it);
        if (typed) begin
            awaited.push_back(want);
        end else begin
            foreach (step_replies[k]) awaited.push_back(step_replies[k]);
        end
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // A tick or an empty dispatch can still be running once the last beat is in.
    task automatic drain();
        start <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_div(logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tick_div = v;
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (awaited.size() == 0) begin
                $display("%0t: extra beat kind %0d task %02h slot %0d st %0d ok %0d last %0d",
                         $time, o_result.resp_kind, o_result.out_task, o_result.slot_index,
                         o_result.task_status, o_result.ok, o_result.last);
                errors++;
            end else begin
                want_beat = awaited.pop_front();
                if (o_result !== want_beat) begin
                    $display("%0t: expected kind %0d task %02h slot %0d st %0d ok %0d last %0d",
                             $time, want_beat.resp_kind, want_beat.out_task,
                             want_beat.slot_index, want_beat.task_status, want_beat.ok,
                             want_beat.last);
                    $display("%0t: actual   kind %0d task %02h slot %0d st %0d ok %0d last %0d",
                             $time, o_result.resp_kind, o_result.out_task, o_result.slot_index,
                             o_result.task_status, o_result.ok, o_result.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [15:0] divs [N_PHASES];
        t_item       it;
        int          sent;
        int          burst;
        int          gap;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tbl_key[i]    = '0;
            tbl_period[i] = '0;
            tbl_count[i]  = '0;
            tbl_state[i]  = ST_STOPPED;
        end
        presc    = '0;
        tick_div = TICK_DIV_RST;

        plan.push_back(cmd_row(t_item'{CMD_QRY, 8'h00, 16'h0000}, 1, 1'b1,
                               t_result'{K_STAT, 8'h00, 4'd0, ST_STOPPED, 1'b0, 1'b1}));
        plan.push_back(cmd_row(t_item'{CMD_QRY, 8'hFF, 16'hFFFF}, 1, 1'b1,
                               t_result'{K_STAT, 8'hFF, 4'd0, ST_ERROR, 1'b0, 1'b1}));
        plan.push_back(cmd_row(t_item'{CMD_DEL, 8'h55, 16'h0000}, 1, 1'b1,
                               t_result'{K_DEL, 8'h55, 4'd0, ST_ERROR, 1'b0, 1'b1}));
        plan.push_back(cmd_row(t_item'{CMD_DEL, 8'h00, 16'h0000}, 1, 1'b1,
                               t_result'{K_DEL, 8'h00, 4'd0, ST_STOPPED, 1'b1, 1'b1}));
        plan.push_back(cmd_row(t_item'{CMD_DSP, 8'h00, 16'h0000}));
        plan.push_back(cmd_row(t_item'{CMD_ADD, 8'hFF, 16'h0000}, 1, 1'b1,
                               t_result'{K_ADD, 8'hFF, 4'd0, ST_RUNNABLE, 1'b1, 1'b1}));
        plan.push_back(cmd_row(t_item'{CMD_ADD, 8'h00, 16'hFFFF}, 1, 1'b1,
                               t_result'{K_ADD, 8'h00, 4'd1, ST_RUNNABLE, 1'b1, 1'b1}));
        plan.push_back(cmd_row(t_item'{CMD_ADD, 8'hA5, 16'h0001}, 1, 1'b1,
                               t_result'{K_ADD, 8'hA5, 4'd2, ST_RUNNABLE, 1'b1, 1'b1}));
        plan.push_back(cmd_row(t_item'{CMD_DSP, 8'h00, 16'h0000}));
        plan.push_back(cmd_row(t_item'{CMD_TICK, 8'h00, 16'h0000}));
        plan.push_back(div_row(16'd1));
        plan.push_back(cmd_row(t_item'{CMD_TICK, 8'h00, 16'h0000}));
        plan.push_back(cmd_row(t_item'{CMD_DSP, 8'h00, 16'h0000}));
        plan.push_back(cmd_row(t_item'{CMD_QRY, 8'hA5, 16'h0000}, 1, 1'b1,
                               t_result'{K_STAT, 8'hA5, 4'd2, ST_RUNNABLE, 1'b0, 1'b1}));
        plan.push_back(cmd_row(t_item'{CMD_DEL, 8'hFF, 16'h0000}, 1, 1'b1,
                               t_result'{K_DEL, 8'hFF, 4'd0, ST_STOPPED, 1'b1, 1'b1}));
        plan.push_back(cmd_row(t_item'{CMD_QRY, 8'hFF, 16'h0000}, 1, 1'b1,
                               t_result'{K_STAT, 8'hFF, 4'd0, ST_STOPPED, 1'b0, 1'b1}));
        plan.push_back(cmd_row(t_item'{CMD_BAD_HI, 8'hFF, 16'hFFFF}));
        plan.push_back(cmd_row(t_item'{CMD_BAD_LO, 8'h00, 16'h0000}));
        plan.push_back(cmd_row(t_item'{CMD_ADD, 8'h11, 16'h0003}, 14));
        plan.push_back(cmd_row(t_item'{CMD_ADD, 8'h3C, 16'h0007}, 1, 1'b1,
                               t_result'{K_ADD, 8'h3C, 4'd0, ST_ERROR, 1'b0, 1'b1}));
        plan.push_back(div_row(16'hFFFF));
        plan.push_back(cmd_row(t_item'{CMD_TICK, 8'h00, 16'h0000}));
        plan.push_back(div_row(16'd0));
        plan.push_back(cmd_row(t_item'{CMD_TICK, 8'h00, 16'h0000}, 3));
        plan.push_back(cmd_row(t_item'{CMD_DSP, 8'h00, 16'h0000}));

        divs = '{16'd3, 16'd1, 16'd0, 16'd2, 16'd392, 16'hFFFF, 16'd7, 16'd5};
        divs[6] = 16'($urandom_range(1, 12));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                drain();
                write_div(plan[r].div);
            end else begin
                repeat (plan[r].reps) issue(plan[r].it, plan[r].typed, plan[r].want);
            end
        end

        // Each phase starts from an empty pipeline so that the divider can change.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            write_div(divs[ph]);
            sent  = 0;
            burst = $urandom_range(1, 24);
            while (sent < PHASE_CMDS) begin
                it = rand_item();
                issue(it, 1'b0, '0);
                if (it.cmd <= CMD_DSP) begin
                    sent++;
                end
                burst--;
                if (burst == 0) begin
                    burst = $urandom_range(1, 24);
                    gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap > 0) begin
                        pause(gap);
                    end
                end
            end
        end

        drain();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/ptts_pkg.sv
sv/ptts_ctrl.sv
sv/ptts_dp.sv
sv/periodic_task_table_scheduler.sv
dv/periodic_task_table_scheduler_tb.sv
